/* design/kcc_pkg.sv */
// Shared types, constants and helper functions of the kicker charge controller.
package kcc_pkg;

    // Converter word handling and level arithmetic.
    localparam int unsigned ADC_SHIFT     = 6;
    localparam int unsigned ADC_W         = 16;
    localparam int unsigned LEVEL_W       = 11;
    localparam int unsigned CMP_W         = 12;
    localparam int unsigned VOLT_W        = 10;
    localparam int unsigned MARGIN_W      = 8;
    localparam int unsigned DUTY_W        = 8;
    localparam logic [ADC_W-1:0] LEVEL_BASE   = ADC_W'(1100);
    localparam logic [CMP_W-1:0] LEVEL_OFFSET = CMP_W'(300);
    localparam logic [DUTY_W-1:0] DUTY_MASK   = 8'hFC;
    localparam logic [7:0] SPEED_BASE         = 8'h30;
    localparam logic [7:0] SPEED_MAX          = 8'd10;
    localparam logic [CMP_W-1:0] ARG_SCALE    = CMP_W'(10);

    // Stream payload widths.
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 24;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_TARGET  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_CEILING  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HYSTERESIS      = 2'd2;
    localparam logic [VOLT_W-1:0]   RST_DEFAULT_TARGET = 10'd250;
    localparam logic [VOLT_W-1:0]   RST_TARGET_CEILING = 10'd250;
    localparam logic [MARGIN_W-1:0] RST_HYSTERESIS     = 8'd20;

    // Command letters.
    localparam logic [7:0] CMD_DRIBBLE   = 8'h64; // d
    localparam logic [7:0] CMD_KICK      = 8'h6B; // k
    localparam logic [7:0] CMD_CHARGE    = 8'h63; // c
    localparam logic [7:0] CMD_DISCHARGE = 8'h70; // p
    localparam logic [7:0] CMD_STOP      = 8'h73; // s
    localparam logic [7:0] CMD_BEAM      = 8'h62; // b
    localparam logic [7:0] CMD_FULL      = 8'h66; // f
    localparam logic [7:0] CMD_VOLTS     = 8'h76; // v
    localparam logic [7:0] CMD_MINIMUM   = 8'h6D; // m

    typedef struct packed {
        logic              action;
        logic [7:0]        command_code;
        logic [7:0]        arg_first;
        logic [7:0]        arg_second;
        logic [ADC_W-1:0]  adc_raw;
        logic              beam_broken;
    } t_item;

    typedef struct packed {
        logic               charge_enable;
        logic               kick_fired;
        logic               discharge_fired;
        logic [DUTY_W-1:0]  roller_pwm;
        logic [LEVEL_W-1:0] cap_level;
    } t_result;

    typedef struct packed {
        logic                charging;
        logic                maintain_charge;
        logic                armed_on_beam;
        logic                armed_when_full;
        logic                armed_at_minimum;
        logic [VOLT_W-1:0]   target_volts;
        logic [VOLT_W-1:0]   threshold_volts;
        logic [DUTY_W-1:0]   duty_level;
    } t_state;

    typedef struct packed {
        logic [VOLT_W-1:0]   default_target;
        logic [VOLT_W-1:0]   target_ceiling;
        logic [MARGIN_W-1:0] hysteresis_margin;
    } t_cfg;

    // Argument byte times ten, saturated at the ceiling.
    function automatic logic [VOLT_W-1:0] scale_arg(input logic [7:0] arg,
                                                    input logic [VOLT_W-1:0] ceiling);
        logic [CMP_W-1:0] v;
        v = CMP_W'(arg) * ARG_SCALE;
        if (v > CMP_W'(ceiling)) begin
            return ceiling;
        end
        return v[VOLT_W-1:0];
    endfunction

    // Duty for dribbler speeds 0 to 10.
    function automatic logic [DUTY_W-1:0] duty_for_speed(input logic [3:0] speed);
        logic [DUTY_W-1:0] d;
        unique case (speed)
            4'd0:    d = 8'd0;
            4'd1:    d = 8'd25;
            4'd2:    d = 8'd51;
            4'd3:    d = 8'd77;
            4'd4:    d = 8'd102;
            4'd5:    d = 8'd128;
            4'd6:    d = 8'd153;
            4'd7:    d = 8'd179;
            4'd8:    d = 8'd204;
            4'd9:    d = 8'd230;
            4'd10:   d = 8'd255;
            default: d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

/* design/kicker_charge_controller.sv */
// Top level of the kicker charge controller: stream ports, registers and config.
//
// Each accepted transaction is one control pass. The block sustains one
// transaction per clock cycle while the result stream is not stalled; a result
// passes through the input register and then the result register. The
// controller state is read and updated in the single cycle in which an item
// moves from the input register to the result register, so consecutive items
// see each other's effect. Configuration is written through a plain write port
// and takes effect for items processed after the write.
module kicker_charge_controller #(
    parameter int unsigned ADC_SHIFT = kcc_pkg::ADC_SHIFT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // command_code[7:0], arg_first[15:8], arg_second[23:16], adc_raw[39:24],
    // beam_broken[40], zero fill [47:41]
    input  logic [kcc_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // action[0]
    input  logic                                 i_s_axis_tuser,
    // Result stream.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // charge_enable[0], kick_fired[1], discharge_fired[2], roller_pwm[10:3],
    // cap_level[21:11], zero fill [23:22]
    output logic [kcc_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [kcc_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [kcc_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    kcc_pkg::t_item   r_item;
    logic             r_in_valid;
    kcc_pkg::t_state  r_state;
    kcc_pkg::t_state  n_state;
    kcc_pkg::t_cfg    r_cfg;
    kcc_pkg::t_result r_result;
    kcc_pkg::t_result n_result;
    logic             r_out_valid;
    logic             in_accept;
    logic             advance;

    // Handshake: the pass runs when the result register is free or draining.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.action       <= i_s_axis_tuser;
            r_item.command_code <= i_s_axis_tdata[7:0];
            r_item.arg_first    <= i_s_axis_tdata[15:8];
            r_item.arg_second   <= i_s_axis_tdata[23:16];
            r_item.adc_raw      <= i_s_axis_tdata[39:24];
            r_item.beam_broken  <= i_s_axis_tdata[40];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_target    <= kcc_pkg::RST_DEFAULT_TARGET;
            r_cfg.target_ceiling    <= kcc_pkg::RST_TARGET_CEILING;
            r_cfg.hysteresis_margin <= kcc_pkg::RST_HYSTERESIS;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == kcc_pkg::CFG_DEFAULT_TARGET) begin
                r_cfg.default_target <= i_cfg_wdata;
            end
            if (i_cfg_addr == kcc_pkg::CFG_TARGET_CEILING) begin
                r_cfg.target_ceiling <= i_cfg_wdata;
            end
            if (i_cfg_addr == kcc_pkg::CFG_HYSTERESIS) begin
                r_cfg.hysteresis_margin <= i_cfg_wdata[kcc_pkg::MARGIN_W-1:0];
            end
        end
    end

    // Control pass.
    kcc_pass #(
        .ADC_SHIFT (ADC_SHIFT)
    ) u_pass (
        .i_item   (r_item),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_result.cap_level, r_result.roller_pwm,
                              r_result.discharge_fired, r_result.kick_fired,
                              r_result.charge_enable};

endmodule

/* design/kcc_pass.sv */
// Combinational control pass: command decode, hysteresis charging and kick arming.
module kcc_pass #(
    parameter int unsigned ADC_SHIFT = kcc_pkg::ADC_SHIFT
) (
    input  kcc_pkg::t_item   i_item,
    input  kcc_pkg::t_state  i_state,
    input  kcc_pkg::t_cfg    i_cfg,
    output kcc_pkg::t_state  o_state,
    output kcc_pkg::t_result o_result
);

    logic [kcc_pkg::ADC_W-1:0]   shifted;
    logic [kcc_pkg::LEVEL_W-1:0] level;
    logic [kcc_pkg::CMP_W-1:0]   level_ext;
    logic [kcc_pkg::CMP_W-1:0]   margin_ext;
    logic [7:0]                  speed;
    logic [kcc_pkg::VOLT_W-1:0]  scaled_first;
    logic [kcc_pkg::VOLT_W-1:0]  scaled_second;

    // Capacitor level from the converter word, saturated at zero.
    assign shifted   = i_item.adc_raw >> ADC_SHIFT;
    assign level     = (shifted > kcc_pkg::LEVEL_BASE) ? '0
                     : kcc_pkg::LEVEL_W'(kcc_pkg::LEVEL_BASE - shifted);
    assign level_ext  = kcc_pkg::CMP_W'(level);
    assign margin_ext = kcc_pkg::CMP_W'(i_cfg.hysteresis_margin);
    assign speed      = i_item.arg_first - kcc_pkg::SPEED_BASE;
    assign scaled_first  = kcc_pkg::scale_arg(i_item.arg_first, i_cfg.target_ceiling);
    assign scaled_second = kcc_pkg::scale_arg(i_item.arg_second, i_cfg.target_ceiling);

    always_comb begin
        kcc_pkg::t_state s;
        logic kick;
        logic discharge;
        s         = i_state;
        kick      = 1'b0;
        discharge = 1'b0;

        // Command decode.
        if (i_item.action) begin
            unique case (i_item.command_code)
                kcc_pkg::CMD_DRIBBLE: begin
                    if (speed <= kcc_pkg::SPEED_MAX) begin
                        s.duty_level = kcc_pkg::duty_for_speed(speed[3:0]);
                    end
                end
                kcc_pkg::CMD_KICK: begin
                    s.charging        = 1'b0;
                    kick              = 1'b1;
                    s.armed_on_beam   = 1'b0;
                    s.maintain_charge = 1'b0;
                end
                kcc_pkg::CMD_CHARGE: begin
                    s.target_volts    = i_cfg.default_target;
                    s.charging        = 1'b1;
                    s.maintain_charge = 1'b1;
                end
                kcc_pkg::CMD_DISCHARGE: begin
                    s.charging        = 1'b0;
                    discharge         = 1'b1;
                    s.maintain_charge = 1'b0;
                end
                kcc_pkg::CMD_STOP: begin
                    s.charging        = 1'b0;
                    s.armed_on_beam   = 1'b0;
                    s.maintain_charge = 1'b0;
                end
                kcc_pkg::CMD_BEAM: begin
                    s.target_volts    = i_cfg.default_target;
                    s.charging        = 1'b1;
                    s.maintain_charge = 1'b1;
                    s.armed_on_beam   = 1'b1;
                end
                kcc_pkg::CMD_FULL: begin
                    s.target_volts    = scaled_first;
                    s.charging        = 1'b1;
                    s.maintain_charge = 1'b1;
                    s.armed_when_full = 1'b1;
                end
                kcc_pkg::CMD_VOLTS: begin
                    s.target_volts    = scaled_first;
                    s.charging        = 1'b1;
                    s.maintain_charge = 1'b1;
                end
                kcc_pkg::CMD_MINIMUM: begin
                    s.armed_at_minimum = 1'b1;
                    s.threshold_volts  = scaled_second;
                    s.target_volts     = scaled_first;
                    s.charging         = 1'b1;
                    s.maintain_charge  = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // Minimum threshold reached: hand over to beam arming.
        if (s.armed_at_minimum && level_ext >
            kcc_pkg::CMP_W'(s.threshold_volts) + margin_ext + kcc_pkg::LEVEL_OFFSET) begin
            s.armed_on_beam    = 1'b1;
            s.armed_at_minimum = 1'b0;
        end

        // Upper hysteresis edge stops the charger and may arm the beam.
        if (s.charging && level_ext >
            kcc_pkg::CMP_W'(s.target_volts) + margin_ext + kcc_pkg::LEVEL_OFFSET) begin
            s.charging = 1'b0;
            if (s.armed_when_full) begin
                s.armed_on_beam   = 1'b1;
                s.armed_when_full = 1'b0;
            end else if (s.armed_at_minimum) begin
                s.armed_on_beam    = 1'b1;
                s.armed_at_minimum = 1'b0;
            end
        end

        // Lower hysteresis edge restarts a maintained charge.
        if (s.maintain_charge && !s.charging &&
            (level_ext + margin_ext < kcc_pkg::CMP_W'(s.target_volts) + kcc_pkg::LEVEL_OFFSET))
        begin
            s.charging = 1'b1;
        end

        // Ball in the beam while armed fires the kick.
        if (i_item.beam_broken && s.armed_on_beam) begin
            s.armed_on_beam   = 1'b0;
            s.charging        = 1'b0;
            kick              = 1'b1;
            s.maintain_charge = 1'b0;
        end

        o_state                  = s;
        o_result.charge_enable   = s.charging;
        o_result.kick_fired      = kick;
        o_result.discharge_fired = discharge;
        o_result.roller_pwm      = s.duty_level & kcc_pkg::DUTY_MASK;
        o_result.cap_level       = level;
    end

endmodule

/* design/kcc_checker.sv */
// Port-level checks of the kicker charge controller and their bind.
module kcc_port_checks (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [kcc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result transaction holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // No result right after reset.
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A kick always leaves the charger off.
    a_kick_stops_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> !o_m_axis_tdata[0])
        else $error("charger on in a kick pass");

    // Duty is masked and the level stays within its base.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[4:3] == 2'b00) &&
            (o_m_axis_tdata[21:11] <= 11'd1100))
        else $error("result field out of range");

endmodule

bind kicker_charge_controller kcc_port_checks u_kcc_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/kcc_checker.sv */
// Checker for the kicker charge controller: tracks both streams, predicts each pass, compares.
module kcc_checker
    import kcc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream as seen on the bus.
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic                   i_in_user,
    // Result stream as seen on the bus.
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    // Register writes.
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                     o_errors,
    output int                     o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Controller state and register copies kept by the checker.
    t_state  ctrl;
    t_cfg    regs;
    t_result pass_results_q[$];

    // Print one line for a failure and count it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        o_errors++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
        end
    endtask

    // Dribbler duty for speeds 0 to 10.
    function automatic logic [DUTY_W-1:0] duty_of_speed(input logic [3:0] speed);
        case (speed)
            4'd0:    return 8'd0;
            4'd1:    return 8'd25;
            4'd2:    return 8'd51;
            4'd3:    return 8'd77;
            4'd4:    return 8'd102;
            4'd5:    return 8'd128;
            4'd6:    return 8'd153;
            4'd7:    return 8'd179;
            4'd8:    return 8'd204;
            4'd9:    return 8'd230;
            default: return 8'd255;
        endcase
    endfunction

    // Argument byte in tens of volts, limited by the ceiling register.
    function automatic logic [VOLT_W-1:0] capped_volts(input logic [7:0] arg);
        int unsigned volts;
        volts = arg * ARG_SCALE;
        if (volts > regs.target_ceiling) begin
            volts = regs.target_ceiling;
        end
        return volts[VOLT_W-1:0];
    endfunction

    function automatic void begin_charge(input logic [VOLT_W-1:0] volts);
        ctrl.target_volts    = volts;
        ctrl.charging        = 1'b1;
        ctrl.maintain_charge = 1'b1;
    endfunction

    // One control pass: updates the controller state and returns its result.
    function automatic t_result run_pass(input t_item it);
        int unsigned shifted;
        int unsigned level;
        int unsigned margin;
        logic [7:0]  speed;
        t_result     res;
        shifted = it.adc_raw >> ADC_SHIFT;
        level   = (shifted > LEVEL_BASE) ? 0 : LEVEL_BASE - shifted;
        margin  = regs.hysteresis_margin;
        res     = '0;

        if (it.action) begin
            case (it.command_code)
                CMD_DRIBBLE: begin
                    speed = it.arg_first - SPEED_BASE;
                    if (speed <= SPEED_MAX) begin
                        ctrl.duty_level = duty_of_speed(speed[3:0]);
                    end
                end
                CMD_KICK: begin
                    ctrl.charging        = 1'b0;
                    ctrl.armed_on_beam   = 1'b0;
                    ctrl.maintain_charge = 1'b0;
                    res.kick_fired       = 1'b1;
                end
                CMD_CHARGE: begin
                    begin_charge(regs.default_target);
                end
                CMD_DISCHARGE: begin
                    ctrl.charging        = 1'b0;
                    ctrl.maintain_charge = 1'b0;
                    res.discharge_fired  = 1'b1;
                end
                CMD_STOP: begin
                    ctrl.charging        = 1'b0;
                    ctrl.armed_on_beam   = 1'b0;
                    ctrl.maintain_charge = 1'b0;
                end
                CMD_BEAM: begin
                    begin_charge(regs.default_target);
                    ctrl.armed_on_beam = 1'b1;
                end
                CMD_FULL: begin
                    begin_charge(capped_volts(it.arg_first));
                    ctrl.armed_when_full = 1'b1;
                end
                CMD_VOLTS: begin
                    begin_charge(capped_volts(it.arg_first));
                end
                CMD_MINIMUM: begin
                    ctrl.armed_at_minimum = 1'b1;
                    ctrl.threshold_volts  = capped_volts(it.arg_second);
                    begin_charge(capped_volts(it.arg_first));
                end
                default: ;
            endcase
        end

        // Minimum threshold passed: hand over to the beam.
        if (ctrl.armed_at_minimum && level > ctrl.threshold_volts + margin + LEVEL_OFFSET) begin
            ctrl.armed_on_beam    = 1'b1;
            ctrl.armed_at_minimum = 1'b0;
        end

        // Upper edge of the band: charge is full.
        if (ctrl.charging && level > ctrl.target_volts + margin + LEVEL_OFFSET) begin
            ctrl.charging = 1'b0;
            if (ctrl.armed_when_full) begin
                ctrl.armed_on_beam   = 1'b1;
                ctrl.armed_when_full = 1'b0;
            end else if (ctrl.armed_at_minimum) begin
                ctrl.armed_on_beam    = 1'b1;
                ctrl.armed_at_minimum = 1'b0;
            end
        end

        // Lower edge of the band: resume a maintained charge.
        if (ctrl.maintain_charge && !ctrl.charging &&
            level + margin < ctrl.target_volts + LEVEL_OFFSET) begin
            ctrl.charging = 1'b1;
        end

        // Ball in the beam while armed fires the kick.
        if (it.beam_broken && ctrl.armed_on_beam) begin
            ctrl.armed_on_beam   = 1'b0;
            ctrl.charging        = 1'b0;
            ctrl.maintain_charge = 1'b0;
            res.kick_fired       = 1'b1;
        end

        res.charge_enable = ctrl.charging;
        res.roller_pwm    = ctrl.duty_level & DUTY_MASK;
        res.cap_level     = level[LEVEL_W-1:0];
        return res;
    endfunction

    // Watch both streams and the register port at every rising edge.
    always @(posedge i_clk) begin
        t_item   item;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            ctrl                   = '0;
            regs.default_target    = RST_DEFAULT_TARGET;
            regs.target_ceiling    = RST_TARGET_CEILING;
            regs.hysteresis_margin = RST_HYSTERESIS;
            pass_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DEFAULT_TARGET: regs.default_target    = i_cfg_wdata[VOLT_W-1:0];
                    CFG_TARGET_CEILING: regs.target_ceiling    = i_cfg_wdata[VOLT_W-1:0];
                    CFG_HYSTERESIS:     regs.hysteresis_margin = i_cfg_wdata[MARGIN_W-1:0];
                    default: ;
                endcase
            end

            // Result transaction: compare with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                got.charge_enable   = i_out_data[0];
                got.kick_fired      = i_out_data[1];
                got.discharge_fired = i_out_data[2];
                got.roller_pwm      = i_out_data[10:3];
                got.cap_level       = i_out_data[21:11];
                if (pass_results_q.size() == 0) begin
                    report_mismatch("result transaction with no pass outstanding");
                end else begin
                    want = pass_results_q.pop_front();
                    check_field("charge_enable", got.charge_enable, want.charge_enable);
                    check_field("kick_fired", got.kick_fired, want.kick_fired);
                    check_field("discharge_fired", got.discharge_fired,
                                want.discharge_fired);
                    check_field("roller_pwm", got.roller_pwm, want.roller_pwm);
                    check_field("cap_level", got.cap_level, want.cap_level);
                end
            end

            // Input transaction: run the pass and queue its result.
            if (i_in_valid && i_in_ready) begin
                item.action       = i_in_user;
                item.command_code = i_in_data[7:0];
                item.arg_first    = i_in_data[15:8];
                item.arg_second   = i_in_data[23:16];
                item.adc_raw      = i_in_data[39:24];
                item.beam_broken  = i_in_data[40];
                pass_results_q.push_back(run_pass(item));
            end
        end
        o_outstanding <= pass_results_q.size();
    end

endmodule

/* tb/tb_kicker_charge_controller.sv */
// Testbench top for the kicker charge controller: clock, reset, stimulus and verdict.
module tb_kicker_charge_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import kcc_pkg::*;

    localparam int RX_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 4;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata    = '0;
    logic                   s_tuser    = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready   = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we     = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

    int mismatches;
    int outstanding;
    int tx_idle_pct   = 0;
    int cap_sim       = 300;
    bit random_active = 1'b0;

    always #5 clk = ~clk;

    kicker_charge_controller DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    kcc_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (s_tvalid),
        .i_in_ready    (s_tready),
        .i_in_data     (s_tdata),
        .i_in_user     (s_tuser),
        .i_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .i_out_data    (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .o_errors      (mismatches),
        .o_outstanding (outstanding)
    );

    // Idle length: none unless the given percent chance hits; then mostly short, now and then long.
    function automatic int idle_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 7) != 0) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Converter word whose upper bits give the requested capacitor level.
    function automatic logic [ADC_W-1:0] adc_for_level(input int lvl);
        logic [9:0] shifted;
        shifted = 10'(int'(LEVEL_BASE) - lvl);
        return {shifted, 6'($urandom_range(0, 63))};
    endfunction

    function automatic t_item make_item(input logic action, input logic [7:0] code,
                                        input logic [7:0] arg1, input logic [7:0] arg2,
                                        input logic [ADC_W-1:0] adc, input logic beam);
        t_item it;
        it.action       = action;
        it.command_code = code;
        it.arg_first    = arg1;
        it.arg_second   = arg2;
        it.adc_raw      = adc;
        it.beam_broken  = beam;
        return it;
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 9))
            0:       return CMD_DRIBBLE;
            1:       return CMD_KICK;
            2:       return CMD_CHARGE;
            3:       return CMD_DISCHARGE;
            4:       return CMD_STOP;
            5:       return CMD_BEAM;
            6:       return CMD_FULL;
            7:       return CMD_VOLTS;
            8:       return CMD_MINIMUM;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Speed characters for the dribbler, small voltages for charge commands.
    function automatic logic [7:0] pick_arg(input logic [7:0] code);
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        if (code == CMD_DRIBBLE) begin
            return SPEED_BASE + 8'($urandom_range(0, 11));
        end
        return 8'($urandom_range(0, 40));
    endfunction

    // Offer one input transaction and hold it until accepted.
    task automatic send_item(input t_item it);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {7'b0, it.beam_broken, it.adc_raw, it.arg_second, it.arg_first,
                     it.command_code};
        do @(posedge clk); while (!s_tready);
        gap = idle_gap(tx_idle_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {7'b0, 41'({$urandom, $urandom})};
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering until every predicted result has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Write all three registers while the block is idle.
    task automatic reconfigure(input int target, input int ceiling, input int margin);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_DEFAULT_TARGET;
        cfg_wdata <= CFG_DATA_W'(target);
        @(posedge clk);
        cfg_addr  <= CFG_TARGET_CEILING;
        cfg_wdata <= CFG_DATA_W'(ceiling);
        @(posedge clk);
        cfg_addr  <= CFG_HYSTERESIS;
        cfg_wdata <= CFG_DATA_W'(margin);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A command followed by passes in which the capacitor level ramps.
    task automatic play_charge_run(output int count);
        logic [7:0] code;
        int         len;
        bit         rising;
        code = pick_command();
        send_item(make_item(1'b1, code, pick_arg(code), pick_arg(code),
                            adc_for_level(cap_sim), $urandom_range(0, 5) == 0));
        count  = 1;
        len    = $urandom_range(3, 24);
        rising = $urandom_range(0, 9) < 7;
        repeat (len) begin
            cap_sim += int'($urandom_range(0, 70)) - (rising ? 15 : 55);
            if (cap_sim < 77) cap_sim = 77;
            if (cap_sim > 1100) cap_sim = 1100;
            code = pick_command();
            send_item(make_item($urandom_range(0, 9) == 0, code, pick_arg(code),
                                pick_arg(code), adc_for_level(cap_sim),
                                $urandom_range(0, 7) == 0));
            count++;
        end
    endtask

    // Fully random transactions.
    task automatic play_noise(output int count);
        int len;
        len   = $urandom_range(1, 10);
        count = len;
        repeat (len) begin
            send_item(make_item($urandom_range(0, 1), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                16'($urandom_range(0, 65535)), $urandom_range(0, 1)));
        end
    endtask

    task automatic run_random(input int n_items);
        int sent;
        int got;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 20;
                default: tx_idle_pct = 50;
            endcase
            if ($urandom_range(0, 9) < 7) begin
                play_charge_run(got);
            end else begin
                play_noise(got);
            end
            sent += got;
            if ($urandom_range(0, 39) == 0) begin
                wait_drained();
            end
        end
    endtask

    // Result side: random ready stretches, and long hold-offs during random traffic.
    initial begin : result_sink
        int bursts_since_hold;
        int rx_idle_pct;
        int span;
        bursts_since_hold = 0;
        rx_idle_pct       = 0;
        wait (rst_n === 1'b1);
        forever begin
            bursts_since_hold++;
            if (bursts_since_hold % 16 == 0) begin
                rx_idle_pct = 30 * int'($urandom_range(0, 2));
            end
            if (random_active && bursts_since_hold > 48) begin
                bursts_since_hold = 0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            span = idle_gap(rx_idle_pct);
            if (span > 0) begin
                m_tready <= 1'b0;
                repeat (span) @(posedge clk);
            end
        end
    end

    // Stimulus: directed passes, then random traffic under several register settings.
    initial begin : stimulus
        t_item plan[$];
        // Ignored command, converter extremes and dribbler speed edge cases.
        plan.push_back(make_item(1'b0, CMD_KICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b1));
        plan.push_back(make_item(1'b1, CMD_DRIBBLE, "5", 8'h00, 16'h0000, 1'b0));
        plan.push_back(make_item(1'b1, CMD_DRIBBLE, ":", 8'h00, adc_for_level(300), 1'b0));
        plan.push_back(make_item(1'b1, CMD_DRIBBLE, 8'h3B, 8'h00, adc_for_level(300), 1'b0));
        plan.push_back(make_item(1'b1, CMD_DRIBBLE, 8'h2F, 8'h00, adc_for_level(300), 1'b0));
        plan.push_back(make_item(1'b1, CMD_DRIBBLE, "0", 8'h00, adc_for_level(300), 1'b0));
        plan.push_back(make_item(1'b1, CMD_DRIBBLE, 8'hFF, 8'h00, adc_for_level(300), 1'b0));
        // Maintained charge through the hysteresis band.
        plan.push_back(make_item(1'b1, CMD_CHARGE, 8'h00, 8'h00, adc_for_level(300), 1'b0));
        plan.push_back(make_item(1'b0, 8'h00, 8'h00, 8'h00, adc_for_level(600), 1'b0));
        plan.push_back(make_item(1'b0, 8'h00, 8'h00, 8'h00, adc_for_level(540), 1'b0));
        plan.push_back(make_item(1'b0, 8'h00, 8'h00, 8'h00, adc_for_level(500), 1'b0));
        plan.push_back(make_item(1'b1, CMD_DISCHARGE, 8'h00, 8'h00, adc_for_level(500), 1'b0));
        // Beam kick, kick on full charge, beam arming after the minimum threshold.
        plan.push_back(make_item(1'b1, CMD_BEAM, 8'h00, 8'h00, adc_for_level(200), 1'b0));
        plan.push_back(make_item(1'b0, 8'h00, 8'h00, 8'h00, adc_for_level(200), 1'b1));
        plan.push_back(make_item(1'b1, CMD_FULL, 8'd20, 8'h00, adc_for_level(300), 1'b0));
        plan.push_back(make_item(1'b0, 8'h00, 8'h00, 8'h00, adc_for_level(600), 1'b0));
        plan.push_back(make_item(1'b0, 8'h00, 8'h00, 8'h00, adc_for_level(600), 1'b1));
        plan.push_back(make_item(1'b1, CMD_MINIMUM, 8'hFF, 8'd5, adc_for_level(300), 1'b0));
        plan.push_back(make_item(1'b0, 8'h00, 8'h00, 8'h00, adc_for_level(400), 1'b0));
        plan.push_back(make_item(1'b1, CMD_STOP, 8'h00, 8'h00, adc_for_level(400), 1'b0));
        // Saturated target, plain kick, unknown letter, zero target.
        plan.push_back(make_item(1'b1, CMD_VOLTS, 8'hFF, 8'h00, adc_for_level(100), 1'b0));
        plan.push_back(make_item(1'b1, CMD_KICK, 8'h00, 8'h00, adc_for_level(100), 1'b0));
        plan.push_back(make_item(1'b1, "x", 8'h00, 8'h00, adc_for_level(100), 1'b1));
        plan.push_back(make_item(1'b1, CMD_FULL, 8'h00, 8'h00, adc_for_level(1100), 1'b0));
        plan.push_back(make_item(1'b0, 8'h00, 8'h00, 8'h00, adc_for_level(1100), 1'b1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 30;
        foreach (plan[i]) begin
            send_item(plan[i]);
        end

        random_active = 1'b1;
        run_random(300);
        reconfigure(0, 0, 0);
        run_random(250);
        reconfigure(1023, 1023, 255);
        run_random(250);
        repeat (3) begin
            reconfigure($urandom_range(0, 600), $urandom_range(0, 1023),
                        $urandom_range(0, 255));
            run_random(250);
        end
        reconfigure(250, 250, 20);
        run_random(150);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
design/kcc_pkg.sv
design/kcc_pass.sv
design/kicker_charge_controller.sv
design/kcc_checker.sv
tb/kcc_checker.sv
tb/tb_kicker_charge_controller.sv
